/* rtl/isakmp_sa_payload_parser_core_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef ISAKMP_SA_PAYLOAD_PARSER_CORE_DEFINES_SVH
`define ISAKMP_SA_PAYLOAD_PARSER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SAP_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SAP_ASSERT_NEXT(label, clk, rst_n, cond, exp) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (exp)) \
        else $error("assertion failed");
`else
`define SAP_ASSERT_IMPL(label, clk, rst_n, prop)
`define SAP_ASSERT_NEXT(label, clk, rst_n, cond, exp)
`endif
`endif

/* rtl/sap_pkg.sv */
// Shared types and constants of the SA payload parser.
package sap_pkg;
    localparam int unsigned PROPOSAL_LIMIT_DEF  = 8;
    localparam int unsigned TRANSFORM_LIMIT_DEF = 8;
    localparam int unsigned ATTRIBUTE_LIMIT_DEF = 16;

    localparam logic [7:0]  PT_PROPOSAL  = 8'd2;
    localparam logic [7:0]  PT_TRANSFORM = 8'd3;
    localparam logic [15:0] MIN_HDR_LEN  = 16'd8;  // 4 + 4
    localparam logic [15:0] TV_FLAG      = 16'h8000;
    localparam logic [15:0] TYPE_MASK    = 16'h7FFF;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DOI, PH_SIT, PH_PHDR, PH_PBODY, PH_SPI, PH_THDR, PH_TBODY,
        PH_ATYPE, PH_ALEN, PH_AVAL, PH_DONE, PH_SWALLOW
    } t_phase;

    typedef enum logic [2:0] {
        RK_DOI, RK_SIT, RK_PROP, RK_SPI, RK_XFORM, RK_ATTR, RK_VERDICT
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK, ST_SHORT, ST_BADLEN, ST_RESERVED, ST_NEXT, ST_PROPLIM, ST_XFLIM,
        ST_ATTRLIM, ST_OVERRUN, ST_ATTRLEN, ST_LONG
    } t_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [14:0] atype;
        logic [7:0]  num;
        logic [7:0]  id;
        logic [7:0]  count;
        logic [3:0]  status;
        logic        done;
    } t_rec;

    // One queue entry: up to two records caused by one byte.
    typedef struct packed {
        logic  v0;
        logic  v1;
        t_rec  r0;
        t_rec  r1;
    } t_pair;
endpackage

/* rtl/sap_front.sv */
// Front part: takes bytes, runs the parse state machine, forms records.
module sap_front #(
    parameter int unsigned PROPOSAL_LIMIT  = sap_pkg::PROPOSAL_LIMIT_DEF,
    parameter int unsigned TRANSFORM_LIMIT = sap_pkg::TRANSFORM_LIMIT_DEF,
    parameter int unsigned ATTRIBUTE_LIMIT = sap_pkg::ATTRIBUTE_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_first_byte,
    input  logic          i_final_byte,
    input  logic [15:0]   i_packet_bytes,
    output sap_pkg::t_pair o_pair
);
    import sap_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_fbc, n_fbc;
    logic [15:0] r_pos, n_pos, r_blen, n_blen, r_hlen, n_hlen, r_tend, n_tend;
    logic [7:0]  r_pcnt, n_pcnt;
    logic [7:0]  r_tidx, n_tidx, r_tdecl, n_tdecl, r_spi, n_spi;
    logic [4:0]  r_acnt, n_acnt;
    logic [7:0]  r_nps, n_nps, r_pnext, n_pnext;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_avl, n_avl;
    logic [3:0]  r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_fbc <= '0; r_pos <= '0; r_blen <= '0;
            r_hlen <= '0; r_tend <= '0; r_pcnt <= '0; r_tidx <= '0;
            r_tdecl <= '0; r_acnt <= '0; r_spi <= '0; r_nps <= '0;
            r_pnext <= '0; r_word <= '0; r_avl <= '0; r_err <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_fbc <= n_fbc; r_pos <= n_pos; r_blen <= n_blen;
            r_hlen <= n_hlen; r_tend <= n_tend; r_pcnt <= n_pcnt; r_tidx <= n_tidx;
            r_tdecl <= n_tdecl; r_acnt <= n_acnt; r_spi <= n_spi; r_nps <= n_nps;
            r_pnext <= n_pnext; r_word <= n_word; r_avl <= n_avl; r_err <= n_err;
        end
    end

    always_comb begin
        t_phase      ph;
        logic [2:0]  fbc;
        logic [15:0] pos, blen, rem;
        logic [31:0] w;
        logic [7:0]  a, c, d, e, pn;
        logic [16:0] rem4;
        logic [15:0] hl;
        logic [7:0]  tdecl, nps, tidx_inc;
        logic        go_pend;
        t_phase      go_to;
        logic        fin;
        t_phase      sel;
        t_rec        rec;

        n_phase = r_phase; n_fbc = r_fbc; n_pos = r_pos; n_blen = r_blen;
        n_hlen = r_hlen; n_tend = r_tend; n_pcnt = r_pcnt; n_tidx = r_tidx;
        n_tdecl = r_tdecl; n_acnt = r_acnt; n_spi = r_spi; n_nps = r_nps;
        n_pnext = r_pnext; n_word = r_word; n_avl = r_avl; n_err = r_err;
        o_pair = '0;
        rec = '0;
        go_pend = 1'b0; go_to = PH_IDLE; fin = 1'b0; sel = PH_IDLE;
        rem = '0; rem4 = '0; hl = '0; tdecl = '0; nps = '0; tidx_inc = '0;
        pn = '0; a = '0; c = '0; d = '0; e = '0;

        ph = r_phase; fbc = r_fbc; pos = r_pos; blen = r_blen; w = r_word;
        if (i_first_byte) begin
            ph = PH_DOI; fbc = '0; pos = '0; blen = i_packet_bytes; w = '0;
            n_hlen = '0; n_tend = '0; n_pcnt = '0; n_tidx = '0; n_tdecl = '0;
            n_acnt = '0; n_spi = '0; n_nps = '0; n_pnext = '0; n_avl = '0;
            n_err = '0;
        end
        n_blen = blen;

        if (ph != PH_IDLE) begin
            pos = pos + 16'd1;
            w = {w[23:0], i_data_byte};
            fbc = fbc + 3'd1;
            a = w[31:24]; c = w[23:16]; d = w[15:8]; e = w[7:0];
            rem = (blen > pos) ? blen - pos : 16'd0;
            rem4 = {1'b0, rem} + 17'd4;
            n_pos = pos; n_word = w; n_fbc = fbc; n_phase = ph;
            tdecl = n_tdecl; nps = n_nps; tidx_inc = n_tidx + 8'd1;
            // sel picks a follow-on action: PH_PBODY begin transforms,
            // PH_TBODY attribute check.
            case (ph)
                PH_DOI, PH_SIT: begin
                    if (fbc == 3'd4) begin
                        rec.kind = (ph == PH_DOI) ? RK_DOI : RK_SIT;
                        rec.value = w;
                        o_pair.v0 = 1'b1;
                        go_pend = 1'b1; go_to = (ph == PH_DOI) ? PH_SIT : PH_PHDR;
                    end
                end
                PH_PHDR, PH_THDR: begin
                    if (fbc == 3'd4) begin
                        hl = w[15:0];
                        if ({1'b0, hl} > rem4 || hl < MIN_HDR_LEN) begin
                            n_err = ST_BADLEN; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else if (c != 8'd0) begin
                            n_err = ST_RESERVED; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else if (a != 8'd0 &&
                                     a != ((ph == PH_PHDR) ? PT_PROPOSAL : PT_TRANSFORM)) begin
                            n_err = ST_NEXT; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else begin
                            n_hlen = hl; go_pend = 1'b1;
                            if (ph == PH_PHDR) begin
                                n_pnext = a; go_to = PH_PBODY;
                            end else begin
                                n_nps = a; go_to = PH_TBODY;
                            end
                        end
                    end
                end
                PH_PBODY: begin
                    if (fbc == 3'd4) begin
                        if (d != 8'd0 && {1'b0, r_hlen} < 17'd8 + {9'd0, d}) begin
                            n_err = ST_BADLEN; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else if ({24'd0, e} > TRANSFORM_LIMIT) begin
                            n_err = ST_XFLIM; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else begin
                            rec.kind = RK_PROP; rec.value = {24'd0, d};
                            rec.num = a; rec.id = c; rec.count = e;
                            o_pair.v0 = 1'b1;
                            n_tdecl = e; tdecl = e; n_tidx = '0; n_spi = d;
                            if (d != 8'd0) begin
                                go_pend = 1'b1; go_to = PH_SPI;
                            end else sel = PH_PBODY;
                        end
                    end
                end
                PH_SPI: begin
                    rec.kind = RK_SPI; rec.value = {24'd0, i_data_byte};
                    o_pair.v0 = 1'b1;
                    n_fbc = '0; n_word = '0;
                    n_spi = r_spi - 8'd1;
                    if (n_spi == 8'd0) sel = PH_PBODY;
                end
                PH_TBODY: begin
                    if (fbc == 3'd4) begin
                        if (d != 8'd0 || e != 8'd0) begin
                            n_err = ST_RESERVED; go_pend = 1'b1; go_to = PH_SWALLOW;
                        end else begin
                            rec.kind = RK_XFORM; rec.num = a; rec.id = c;
                            rec.count = r_tidx;
                            o_pair.v0 = 1'b1;
                            n_tend = pos + r_hlen - MIN_HDR_LEN;
                            n_acnt = '0;
                            sel = PH_TBODY;
                        end
                    end
                end
                PH_ATYPE: begin
                    if (fbc == 3'd2) begin
                        n_hlen = w[15:0] & TYPE_MASK;
                        go_pend = 1'b1;
                        if ((w[15:0] & TV_FLAG) != 16'd0) begin
                            n_avl = 3'd2; go_to = PH_AVAL;
                        end else go_to = PH_ALEN;
                    end
                end
                PH_ALEN: begin
                    if (fbc == 3'd2) begin
                        go_pend = 1'b1;
                        if (w == 32'd2 || w == 32'd4) begin
                            n_avl = w[2:0]; go_to = PH_AVAL;
                        end else begin
                            n_err = ST_ATTRLEN; go_to = PH_SWALLOW;
                        end
                    end
                end
                PH_AVAL: begin
                    if (fbc >= r_avl) begin
                        rec.kind = RK_ATTR; rec.value = w; rec.atype = r_hlen[14:0];
                        o_pair.v0 = 1'b1;
                        n_acnt = r_acnt + 5'd1;
                        sel = PH_TBODY;
                    end
                end
                PH_DONE: begin
                    n_err = ST_LONG; go_pend = 1'b1; go_to = PH_SWALLOW;
                end
                default: begin
                    n_fbc = '0; n_word = '0;
                end
            endcase

            // Attribute check folds into finish-transform, which folds into
            // begin-transforms' finish-proposal.
            if (sel == PH_TBODY) begin
                go_pend = 1'b1;
                if (pos >= n_tend) begin
                    if (pos > n_tend) begin
                        n_err = ST_OVERRUN; go_to = PH_SWALLOW;
                    end else begin
                        n_tidx = tidx_inc;
                        if (tidx_inc < tdecl) begin
                            if (nps == 8'd0) begin
                                n_err = ST_NEXT; go_to = PH_SWALLOW;
                            end else go_to = PH_THDR;
                        end else if (nps != 8'd0) begin
                            n_err = ST_NEXT; go_to = PH_SWALLOW;
                        end else fin = 1'b1;
                    end
                end else if ({27'd0, n_acnt} >= ATTRIBUTE_LIMIT) begin
                    n_err = ST_ATTRLIM; go_to = PH_SWALLOW;
                end else go_to = PH_ATYPE;
            end else if (sel == PH_PBODY) begin
                go_pend = 1'b1;
                if (tdecl != 8'd0) go_to = PH_THDR;
                else if (nps != 8'd0) begin
                    n_err = ST_NEXT; go_to = PH_SWALLOW;
                end else fin = 1'b1;
            end
            if (fin) begin
                pn = n_pnext;
                n_nps = pn;
                if (pn == 8'd0) go_to = PH_DONE;
                else begin
                    n_pcnt = r_pcnt + 8'd1;
                    if ({24'd0, n_pcnt} >= PROPOSAL_LIMIT) begin
                        n_err = ST_PROPLIM; go_to = PH_SWALLOW;
                    end else go_to = PH_PHDR;
                end
            end
            if (go_pend) begin
                n_phase = go_to; n_fbc = '0; n_word = '0;
            end
            o_pair.r0 = rec;

            if (i_final_byte) begin
                o_pair.v1 = 1'b1;
                o_pair.r1.kind = RK_VERDICT;
                o_pair.r1.status = (n_phase == PH_SWALLOW) ? n_err :
                                   ((n_phase == PH_DONE) ? ST_OK : ST_SHORT);
                o_pair.r1.done = 1'b1;
                n_phase = PH_IDLE; n_fbc = '0; n_word = '0;
            end
        end
    end
endmodule

/* rtl/sap_queue.sv */
// Two-entry queue of record pairs between the front and the back part.
module sap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sap_pkg::t_pair i_pair,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output sap_pkg::t_pair o_pair
);
    import sap_pkg::*;

    t_pair      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_pair  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

/* rtl/sap_back.sv */
// Back part: sends the one or two records of each queue entry out in order.
module sap_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sap_pkg::t_pair i_pair,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output sap_pkg::t_rec  o_rec
);
    import sap_pkg::*;

    logic r_sec;   // first record of the head entry already sent
    logic want0, fire, last;

    assign want0   = i_pair.v0 && !r_sec;
    assign o_valid = !i_empty;
    assign o_rec   = want0 ? i_pair.r0 : i_pair.r1;
    assign fire    = o_valid && !i_stall;
    assign last    = !(want0 && i_pair.v1);
    assign o_pop   = fire && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sec <= 1'b0;
        else if (fire) r_sec <= !last;
    end
endmodule

/* rtl/isakmp_sa_payload_parser_core.sv */
// Top level of the ISAKMP SA payload body parser.
// Channel | Direction | Handshake
// in      | input     | i_valid / o_stall, one body byte per request
// out     | output    | o_valid / i_stall, one record per request
// One byte is accepted per cycle while the queue is not full; a byte
// yields up to two records, sent out one at a time, held in a two-entry
// queue between parse and output. The parse state advances in the cycle a
// byte is accepted. Input stalls only while the queue is full.
// Reset (synchronous, active low) returns the parser to idle.
`include "isakmp_sa_payload_parser_core_defines.svh"
module isakmp_sa_payload_parser_core #(
    parameter int unsigned PROPOSAL_LIMIT  = sap_pkg::PROPOSAL_LIMIT_DEF,
    parameter int unsigned TRANSFORM_LIMIT = sap_pkg::TRANSFORM_LIMIT_DEF,
    parameter int unsigned ATTRIBUTE_LIMIT = sap_pkg::ATTRIBUTE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_final_byte,
    input  logic [15:0] i_packet_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_record_kind,
    output logic [31:0] o_value,
    output logic [14:0] o_attribute_type,
    output logic [7:0]  o_item_number,
    output logic [7:0]  o_protocol_or_id,
    output logic [7:0]  o_item_count,
    output logic [3:0]  o_status,
    output logic        o_packet_done
);
    import sap_pkg::*;

    t_pair f_pair, q_pair;
    t_rec  rec;
    logic  take, full, empty, pop, push;

    assign o_stall = full;
    assign take    = i_valid && !full;
    assign push    = take && (f_pair.v0 || f_pair.v1);

    sap_front #(
        .PROPOSAL_LIMIT(PROPOSAL_LIMIT),
        .TRANSFORM_LIMIT(TRANSFORM_LIMIT),
        .ATTRIBUTE_LIMIT(ATTRIBUTE_LIMIT)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_data_byte(i_data_byte), .i_first_byte(i_first_byte),
        .i_final_byte(i_final_byte), .i_packet_bytes(i_packet_bytes),
        .o_pair(f_pair)
    );

    sap_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_pair(f_pair),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_pair(q_pair)
    );

    sap_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_pair(q_pair),
        .o_pop(pop), .i_stall(i_stall), .o_valid(o_valid), .o_rec(rec)
    );

    assign o_record_kind    = rec.kind;
    assign o_value          = rec.value;
    assign o_attribute_type = rec.atype;
    assign o_item_number    = rec.num;
    assign o_protocol_or_id = rec.id;
    assign o_item_count     = rec.count;
    assign o_status         = rec.status;
    assign o_packet_done    = rec.done;

    `SAP_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, !(pop && empty))
    `SAP_ASSERT_IMPL(a_done_is_verdict, i_clk, i_rst_n,
        (o_valid && o_packet_done) |-> (o_record_kind == RK_VERDICT))
    `SAP_ASSERT_NEXT(a_full_then_live, i_clk, i_rst_n, full, !empty)
endmodule
